// File: src/mcfd_pkg.sv
// Shared types and constants for the motor command frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcfd_pkg;

    // Frame layout
    localparam logic [7:0] FRAME_HEADER = 8'hAA;
    localparam logic [7:0] ID_DRIVE     = 8'h01;
    localparam logic [7:0] ID_FOLD      = 8'h02;
    localparam logic [2:0] LAST_POS     = 3'd6;

    // Duty scaling: duty = mag * pwm_top / 32000 = ((mag * pwm_top) >> 8) / 125
    localparam logic [15:0] SPEED_FULL_SCALE = 16'd32000;
    localparam int unsigned DIV_ODD          = 125;
    localparam int unsigned RECIP_SHIFT      = 30;
    // floor(2^30 / 125), error of the estimate stays below one
    localparam logic [23:0] RECIP            = 24'((64'd1 << RECIP_SHIFT) / DIV_ODD);

    // Register reset values
    localparam logic [15:0] PWM_TOP_RST    = 16'd3359;
    localparam logic [15:0] FOLD_LEFT_RST  = 16'd2500;
    localparam logic [15:0] FOLD_RIGHT_RST = 16'd550;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic [1:0] {
        REG_PWM_TOP    = 2'd0,
        REG_FOLD_LEFT  = 2'd1,
        REG_FOLD_RIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_IGNORE  = 2'd0,
        ACT_DRIVE   = 2'd1,
        ACT_BAD_SUM = 2'd2,
        ACT_FOLD    = 2'd3
    } t_action;

    // One classified frame, front to back
    typedef struct packed {
        t_action     action;
        logic [15:0] spd_left;
        logic [15:0] spd_right;
    } t_cmd;

    typedef struct packed {
        logic [15:0] pwm_top;
        logic [15:0] fold_left;
        logic [15:0] fold_right;
    } t_cfg;

endpackage

// File: src/mcfd_front.sv
// Front end: assembles 7-byte frames, checks header, id, drive checksum.
// Depends on mcfd_pkg; pushes one classified command per frame.
`timescale 1ns / 1ps

module mcfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output mcfd_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import mcfd_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic        r_hdr_ok;
    logic [7:0]  r_id;
    logic [15:0] r_left, r_right;
    logic [7:0]  r_xor;
    logic        accept;
    logic        last;

    // only the frame-closing word needs queue room
    assign last    = (r_pos == LAST_POS);
    assign o_ready = !last || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && last;

    // classify on the closing word
    always_comb begin
        o_cmd.spd_left  = r_left;
        o_cmd.spd_right = r_right;
        if (r_hdr_ok && r_id == ID_DRIVE) begin
            o_cmd.action = (i_byte == r_xor) ? ACT_DRIVE : ACT_BAD_SUM;
        end else if (r_hdr_ok && r_id == ID_FOLD) begin
            o_cmd.action = ACT_FOLD;
        end else begin
            o_cmd.action = ACT_IGNORE;
        end
    end

    assign n_pos = last ? 3'd0 : r_pos + 3'd1;

    // byte position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // frame fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_ok <= 1'b0;
            r_id     <= 8'd0;
            r_left   <= 16'd0;
            r_right  <= 16'd0;
            r_xor    <= 8'd0;
        end else if (accept) begin
            unique case (r_pos)
                3'd0: begin
                    r_hdr_ok <= (i_byte == FRAME_HEADER);
                    r_xor    <= 8'd0;
                end
                3'd1: begin
                    r_id  <= i_byte;
                    r_xor <= i_byte;
                end
                3'd2: begin
                    r_left[7:0] <= i_byte;
                    r_xor       <= r_xor ^ i_byte;
                end
                3'd3: begin
                    r_left[15:8] <= i_byte;
                    r_xor        <= r_xor ^ i_byte;
                end
                3'd4: begin
                    r_right[7:0] <= i_byte;
                    r_xor        <= r_xor ^ i_byte;
                end
                3'd5: begin
                    r_right[15:8] <= i_byte;
                    r_xor         <= r_xor ^ i_byte;
                end
                default: begin
                end
            endcase
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("front: byte position out of range");

endmodule

// File: src/mcfd_queue.sv
// Small command FIFO between frame front end and drive back end.
// Depends on mcfd_pkg for the command type.
`timescale 1ns / 1ps

module mcfd_queue #(
    parameter int DEPTH = mcfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcfd_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output mcfd_pkg::t_cmd o_data,
    output logic           o_empty
);
    import mcfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slots[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue: push while full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue: fill level above depth");

endmodule

// File: src/mcfd_back.sv
// Back end: duty scaling pipeline, held drive settings and result register.
// Depends on mcfd_pkg; takes commands from the queue head.
`timescale 1ns / 1ps

module mcfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mcfd_pkg::t_cfg i_cfg,
    input  mcfd_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_action,
    output logic           o_echo,
    output logic           o_left_fwd,
    output logic [15:0]    o_left_duty,
    output logic           o_right_fwd,
    output logic [15:0]    o_right_duty,
    output logic [15:0]    o_servo_left,
    output logic [15:0]    o_servo_right
);
    import mcfd_pkg::*;

    // lane 0 is the left motor, lane 1 the right
    logic        en;
    logic [15:0] speed [2];
    logic [15:0] mag   [2];

    logic        r1_valid, r2_valid, r3_valid, r_out_valid;
    t_action     r1_act, r2_act, r3_act;
    logic [1:0]  r1_fwd, r2_fwd, r3_fwd;
    logic [1:0]  r1_sat, r2_sat, r3_sat;
    logic [31:0] r1_prod [2];
    logic [22:0] r2_num  [2];
    logic [38:0] r2_pplo [2];
    logic [30:0] r2_pphi [2];
    logic [22:0] r3_num  [2];
    logic [16:0] r3_q0   [2];

    logic [46:0] est   [2];
    logic [23:0] back3 [2];
    logic [23:0] rem   [2];
    logic [16:0] quo   [2];
    logic [15:0] duty  [2];

    t_action     r_action;
    logic        r_echo;
    logic [1:0]  r_fwd;
    logic [15:0] r_duty [2];
    logic [15:0] r_servo_l, r_servo_r;

    // whole pipeline moves when the result slot is free or being taken
    assign en        = !r_out_valid || i_ready;
    assign o_cmd_pop = en && i_cmd_valid;

    assign speed[0] = i_cmd.spd_left;
    assign speed[1] = i_cmd.spd_right;

    // magnitude and quotient correction, per lane
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mag[k]   = speed[k][15] ? 16'(17'h10000 - {1'b0, speed[k]}) : speed[k];
            est[k]   = {8'd0, r2_pplo[k]} + {r2_pphi[k], 16'd0};
            back3[k] = 24'({7'd0, r3_q0[k]} * 24'(DIV_ODD));
            rem[k]   = {1'b0, r3_num[k]} - back3[k];
            quo[k]   = (rem[k] >= 24'(DIV_ODD)) ? r3_q0[k] + 17'd1 : r3_q0[k];
            duty[k]  = r3_sat[k] ? i_cfg.pwm_top : quo[k][15:0];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_cmd_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    // datapath stages: product, partial products of reciprocal, estimate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= i_cmd.action;
            r2_act <= r1_act;
            r3_act <= r2_act;
            r2_fwd <= r1_fwd;
            r3_fwd <= r2_fwd;
            r2_sat <= r1_sat;
            r3_sat <= r2_sat;
            for (int k = 0; k < 2; k++) begin
                r1_fwd[k]  <= !speed[k][15];
                r1_sat[k]  <= (mag[k] >= SPEED_FULL_SCALE);
                r1_prod[k] <= {16'd0, mag[k]} * {16'd0, i_cfg.pwm_top};
                r2_num[k]  <= r1_prod[k][30:8];
                r2_pplo[k] <= {16'd0, r1_prod[k][30:8]} * {23'd0, RECIP[15:0]};
                r2_pphi[k] <= {8'd0, r1_prod[k][30:8]} * {23'd0, RECIP[23:16]};
                r3_num[k]  <= r2_num[k];
                r3_q0[k]   <= est[k][46:RECIP_SHIFT];
            end
        end
    end

    // commit: held settings and result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action  <= ACT_IGNORE;
            r_echo    <= 1'b0;
            r_fwd     <= 2'b00;
            r_duty[0] <= 16'd0;
            r_duty[1] <= 16'd0;
            r_servo_l <= 16'd0;
            r_servo_r <= 16'd0;
        end else if (en && r3_valid) begin
            r_action <= r3_act;
            r_echo   <= (r3_act != ACT_IGNORE);
            unique case (r3_act)
                ACT_DRIVE: begin
                    r_fwd     <= r3_fwd;
                    r_duty[0] <= duty[0];
                    r_duty[1] <= duty[1];
                end
                ACT_FOLD: begin
                    r_duty[0] <= 16'd0;
                    r_duty[1] <= 16'd0;
                    r_servo_l <= i_cfg.fold_left;
                    r_servo_r <= i_cfg.fold_right;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_action      = r_action;
    assign o_echo        = r_echo;
    assign o_left_fwd    = r_fwd[0];
    assign o_left_duty   = r_duty[0];
    assign o_right_fwd   = r_fwd[1];
    assign o_right_duty  = r_duty[1];
    assign o_servo_left  = r_servo_l;
    assign o_servo_right = r_servo_r;

    a_one_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> (rem[0] < 24'(2 * DIV_ODD) && rem[1] < 24'(2 * DIV_ODD)))
        else $error("back: quotient estimate off by more than one");

    a_fold_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r3_valid && r3_act == ACT_FOLD)
            |=> (r_duty[0] == 16'd0 && r_duty[1] == 16'd0 && r_out_valid))
        else $error("back: fold did not clear duties");

    a_echo_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_echo == (r_action != ACT_IGNORE)))
        else $error("back: echo flag disagrees with action");

endmodule

// File: src/motor_command_frame_decoder_core.sv
// Top level of the motor command frame decoder: config registers and wiring.
// Depends on mcfd_pkg, mcfd_front, mcfd_queue and mcfd_back.
//
// Usage:
//   Received serial bytes enter on i_rx_valid / o_rx_ready / i_rx_byte, one
//   word per cycle when ready. Every seventh byte closes a frame; no resync.
//   For each frame one result word leaves on o_res_valid / i_res_ready with
//   the action code, the echo flag and all held drive and servo settings.
//   Other bytes produce nothing.
//   Throughput: one byte per cycle while o_rx_ready is high. Each result is
//   formed by queue write, product, reciprocal partial products and
//   quotient estimate, then correction and commit into the result register.
//   When the receiver stalls, the back pipeline holds and frames collect in
//   a QUEUE_DEPTH-entry queue; once it is full, o_rx_ready drops only for
//   a frame-closing byte.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, by the
//   user only while the block is idle (not enforced); index 3 is ignored.
//   Synchronous active-low reset clears frame position, queue level, stage
//   valids and held settings to zero and loads the register defaults.
`timescale 1ns / 1ps

module motor_command_frame_decoder_core #(
    parameter int QUEUE_DEPTH = mcfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_action,
    output logic        o_echo_frame,
    output logic        o_left_forward,
    output logic [15:0] o_left_duty,
    output logic        o_right_forward,
    output logic [15:0] o_right_duty,
    output logic [15:0] o_servo_left_pulse,
    output logic [15:0] o_servo_right_pulse,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import mcfd_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, q_full, q_empty, pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_top    <= PWM_TOP_RST;
            r_cfg.fold_left  <= FOLD_LEFT_RST;
            r_cfg.fold_right <= FOLD_RIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PWM_TOP:    r_cfg.pwm_top    <= i_cfg_data;
                REG_FOLD_LEFT:  r_cfg.fold_left  <= i_cfg_data;
                REG_FOLD_RIGHT: r_cfg.fold_right <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mcfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .o_ready (o_rx_ready),
        .i_byte  (i_rx_byte),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    mcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    mcfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (head_cmd),
        .i_cmd_valid   (!q_empty),
        .o_cmd_pop     (pop),
        .o_valid       (o_res_valid),
        .i_ready       (i_res_ready),
        .o_action      (o_action),
        .o_echo        (o_echo_frame),
        .o_left_fwd    (o_left_forward),
        .o_left_duty   (o_left_duty),
        .o_right_fwd   (o_right_forward),
        .o_right_duty  (o_right_duty),
        .o_servo_left  (o_servo_left_pulse),
        .o_servo_right (o_servo_right_pulse)
    );

endmodule
